// ===== rtl/bbe_pkg.sv =====
// Shared constants, types and the reciprocal table of the edge-aware 3x3 box blur.
`default_nettype none

package bbe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int IN_ROW_W   = FH_W + 1;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = SUM_W + 1;
    localparam int RCP_W      = 20;
    localparam int PROD_W     = NUM_W + RCP_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_SUM   = 4'b0100,
        S_MUL   = 4'b1000
    } state_t;

    // Rounded mean is floor((2*sum + cnt) * recip(cnt) / 2^RCP_W), with
    // recip(cnt) = ceil(2^RCP_W / (2*cnt)); exact for every numerator below 2^NUM_W.
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        case (cnt)
            4'd1:    r = 20'd524288;
            4'd2:    r = 20'd262144;
            4'd3:    r = 20'd174763;
            4'd4:    r = 20'd131072;
            4'd6:    r = 20'd87382;
            4'd9:    r = 20'd58255;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbe_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// Top level of the edge-aware 3x3 box blur over an RGB raster stream.
//
// Pixels enter on the s_ channel in raster order; s_tuser marks a flush item.
// Each mean counts only neighbours inside the frame and is rounded half up.
// Results leave on the m_ channel; m_tlast marks the frame's final pixel.
// The result for pixel k is produced by input item k + W + 1, so W + 1 flush
// items after the last pixel push out the rest of the frame.
// A pixel item passes through acceptance, the line store
// read-modify-write, the window sum, and the reciprocal multiply into the
// output register. An item that gives no result is done after the line store
// read-modify-write, and a flush item inside the frame is dropped in its acceptance cycle.
// The output register holds a finished result while the next item is taken;
// a stalled receiver holds the block only in its last stage.
// Reset restores the default 640 x 480 geometry and restarts the frame; the
// line stores need no clearing. A configuration write also restarts the frame;
// the user makes it only while the block is idle, which the block does not enforce.
`default_nettype none

module box_blur_3x3_edge_aware (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bbe_pkg::PIX_W-1:0]        s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // padding
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bbe_pkg::PIX_W-1:0]        m_tdata,   // blurred_red, blurred_green, blurred_blue
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W    = bbe_pkg::COL_W;
    localparam int WID_W    = bbe_pkg::WID_W;
    localparam int FW_W     = bbe_pkg::FW_W;
    localparam int FH_W     = bbe_pkg::FH_W;
    localparam int IN_ROW_W = bbe_pkg::IN_ROW_W;
    localparam int CH_W     = bbe_pkg::CH_W;
    localparam int PIX_W    = bbe_pkg::PIX_W;
    localparam int SUM_W    = bbe_pkg::SUM_W;
    localparam int CNT_W    = bbe_pkg::CNT_W;
    localparam int NUM_W    = bbe_pkg::NUM_W;
    localparam int RCP_W    = bbe_pkg::RCP_W;
    localparam int PROD_W   = bbe_pkg::PROD_W;

    bbe_pkg::state_t state_reg, state_next;

    logic [FW_W-1:0]     fw_reg, fw_next;
    logic [FH_W-1:0]     fh_reg, fh_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [FH_W-1:0]     out_row_reg, out_row_next;
    logic [PIX_W-1:0]    win_reg [9];
    logic [PIX_W-1:0]    win_next [9];
    logic [PIX_W-1:0]    px_reg, px_next;
    logic [SUM_W-1:0]    sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
    logic [CNT_W-1:0]    cnt_reg, cnt;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]    m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic [WID_W-1:0]    ew;
    logic [FH_W-1:0]     eh;
    logic                in_frame;
    logic                accept;
    logic [COL_W-1:0]    col_eff;
    logic [WID_W-1:0]    col_plus;
    logic                due;
    logic                ro_last, co_last;
    logic [2:0]          row_ok, col_ok;
    logic [8:0]          mask;
    logic                out_free;
    logic [PIX_W-1:0]    up_rdata, mid_rdata;
    logic                ram_we;
    logic [RCP_W-1:0]    rcp;
    logic [NUM_W-1:0]    num_r, num_g, num_b;
    logic [PROD_W-1:0]   prod_r, prod_g, prod_b;

    always_comb begin
        if (fw_reg == '0) begin
            ew = WID_W'(1);
        end else if (32'(fw_reg) > 32'(bbe_pkg::MAX_WIDTH)) begin
            ew = WID_W'(bbe_pkg::MAX_WIDTH);
        end else begin
            ew = WID_W'(fw_reg);
        end
        eh = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    end

    assign in_frame = in_row_reg < {1'b0, eh};
    assign s_tready = (state_reg == bbe_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign col_eff  = ({1'b0, in_col_reg} >= ew) ? '0 : in_col_reg;
    assign col_plus = {1'b0, col_eff} + WID_W'(1);
    assign due      = (in_row_reg > IN_ROW_W'(1))
                   || ((in_row_reg == IN_ROW_W'(1)) && (col_eff != '0));
    assign ro_last  = ({1'b0, out_row_reg} + IN_ROW_W'(1)) >= {1'b0, eh};
    assign co_last  = ({1'b0, out_col_reg} + WID_W'(1)) >= ew;
    assign row_ok   = {!ro_last, 1'b1, out_row_reg != '0};
    assign col_ok   = {!co_last, 1'b1, out_col_reg != '0};
    assign out_free = !m_valid_reg || m_tready;
    assign ram_we   = (state_reg == bbe_pkg::S_WRITE);

    bbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (bbe_pkg::MAX_WIDTH)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_eff),
        .wdata (mid_rdata),
        .raddr (col_eff),
        .rdata (up_rdata)
    );

    bbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (bbe_pkg::MAX_WIDTH)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_eff),
        .wdata (px_reg),
        .raddr (col_eff),
        .rdata (mid_rdata)
    );

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r*3+c] = row_ok[r] && col_ok[c];
            end
        end
        for (int i = 0; i < 9; i++) begin
            if (mask[i]) begin
                sum_r = sum_r + SUM_W'(win_reg[i][2*CH_W +: CH_W]);
                sum_g = sum_g + SUM_W'(win_reg[i][CH_W +: CH_W]);
                sum_b = sum_b + SUM_W'(win_reg[i][0 +: CH_W]);
            end
        end
        cnt = CNT_W'($countones(mask));
    end

    assign rcp    = bbe_pkg::recip(cnt_reg);
    assign num_r  = {sum_r_reg, 1'b0} + NUM_W'(cnt_reg);
    assign num_g  = {sum_g_reg, 1'b0} + NUM_W'(cnt_reg);
    assign num_b  = {sum_b_reg, 1'b0} + NUM_W'(cnt_reg);
    assign prod_r = PROD_W'(num_r) * PROD_W'(rcp);
    assign prod_g = PROD_W'(num_g) * PROD_W'(rcp);
    assign prod_b = PROD_W'(num_b) * PROD_W'(rcp);

    always_comb begin
        state_next   = state_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        win_next     = win_reg;
        px_next      = px_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            bbe_pkg::S_IDLE: begin
                if (accept && !(in_frame && s_tuser)) begin
                    px_next    = in_frame ? {s_tdata[0 +: CH_W], s_tdata[CH_W +: CH_W],
                                             s_tdata[2*CH_W +: CH_W]} : '0;
                    state_next = bbe_pkg::S_WRITE;
                end
            end
            bbe_pkg::S_WRITE: begin
                for (int r = 0; r < 3; r++) begin
                    win_next[r*3]   = win_reg[r*3+1];
                    win_next[r*3+1] = win_reg[r*3+2];
                end
                win_next[2] = up_rdata;
                win_next[5] = mid_rdata;
                win_next[8] = px_reg;
                if (col_plus >= ew) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + IN_ROW_W'(1);
                end else begin
                    in_col_next = col_plus[COL_W-1:0];
                end
                state_next = due ? bbe_pkg::S_SUM : bbe_pkg::S_IDLE;
            end
            bbe_pkg::S_SUM: begin
                last_next = ro_last && co_last;
                if (ro_last && co_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    for (int i = 0; i < 9; i++) begin
                        win_next[i] = '0;
                    end
                end else if (co_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + FH_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                state_next = bbe_pkg::S_MUL;
            end
            bbe_pkg::S_MUL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {prod_b[RCP_W +: CH_W], prod_g[RCP_W +: CH_W],
                                    prod_r[RCP_W +: CH_W]};
                    m_last_next  = last_reg;
                    state_next   = bbe_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bbe_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (bbe_pkg::cfg_reg_t'(cfg_index))
                bbe_pkg::REG_FRAME_WIDTH:  fw_next = cfg_data[FW_W-1:0];
                bbe_pkg::REG_FRAME_HEIGHT: fh_next = cfg_data[FH_W-1:0];
                default:                   fw_next = fw_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            for (int i = 0; i < 9; i++) begin
                win_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbe_pkg::S_IDLE;
            fw_reg      <= bbe_pkg::FW_RESET;
            fh_reg      <= bbe_pkg::FH_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        if (state_reg == bbe_pkg::S_SUM) begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
            cnt_reg   <= cnt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/bbe_checker.sv =====
// Port-level assertions for the box blur top level, with their bind statement.
`default_nettype none

module bbe_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [bbe_pkg::PIX_W-1:0] m_tdata,
    input logic                      m_tlast
);

    // A result held back by the receiver stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A result held back by the receiver keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A new result never appears in the cycle right after a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too soon after a request");

endmodule

bind box_blur_3x3_edge_aware bbe_checker u_bbe_checker (.*);

`default_nettype wire
